FILE: hdl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// shared widths, region codes and the side-band tag for the distance pipe
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int LEN_W      = PROD_W;
   localparam int HALF_W     = LEN_W / 2;
   localparam int MAG_W      = 2 * LEN_W;
   localparam int DIST_W     = COORD_BITS + FRAC_BITS + 1;
   localparam int QUO_W      = 2 * DIST_W;
   localparam int SHIFT_W    = QUO_W - 2 * FRAC_BITS;
   localparam int ROOT_REM_W = DIST_W + 3;

   typedef enum logic [1:0] {
      REGION_PERP  = 2'd0,
      REGION_END   = 2'd1,
      REGION_START = 2'd2
   } region_type;

   typedef struct packed {
      region_type region;
      logic       degenerate;
   } tag_type;

endpackage

FILE: hdl/psd_divide.sv
// ----------------------------------------------------------------------------
// psd_divide
// pipelined restoring divider, one quotient bit per stage, (num << 2f) / den
// ----------------------------------------------------------------------------
module psd_divide
   import psd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [MAG_W-1:0]   in_num,
   input  logic [LEN_W-1:0]   in_den,
   input  tag_type            in_tag,
   output logic               out_valid,
   output logic [QUO_W-1:0]   out_quo,
   output tag_type            out_tag
);

   logic             valid_ff [QUO_W];
   logic [LEN_W-1:0] rem_ff   [QUO_W];
   logic [QUO_W-1:0] num_ff   [QUO_W];
   logic [QUO_W-1:0] quo_ff   [QUO_W];
   logic [LEN_W-1:0] den_ff   [QUO_W];
   tag_type          tag_ff   [QUO_W];

   logic             valid_pv [QUO_W];
   logic [LEN_W-1:0] rem_pv   [QUO_W];
   logic [QUO_W-1:0] num_pv   [QUO_W];
   logic [QUO_W-1:0] quo_pv   [QUO_W];
   logic [LEN_W-1:0] den_pv   [QUO_W];
   tag_type          tag_pv   [QUO_W];

   genvar i;
   generate
      for (i = 0; i < QUO_W; i++) begin : g_stage
         logic [LEN_W:0]   shift_val;
         logic             take;
         logic [LEN_W-1:0] rem_in;
         logic [QUO_W-1:0] num_in;
         logic [QUO_W-1:0] quo_in;

         if (i == 0) begin : g_first
            assign valid_pv[i] = in_valid;
            assign rem_pv[i]   = in_num[MAG_W-1:SHIFT_W];
            assign num_pv[i]   = {in_num[SHIFT_W-1:0], {(2 * FRAC_BITS){1'b0}}};
            assign quo_pv[i]   = '0;
            assign den_pv[i]   = in_den;
            assign tag_pv[i]   = in_tag;
         end else begin : g_next
            assign valid_pv[i] = valid_ff[i-1];
            assign rem_pv[i]   = rem_ff[i-1];
            assign num_pv[i]   = num_ff[i-1];
            assign quo_pv[i]   = quo_ff[i-1];
            assign den_pv[i]   = den_ff[i-1];
            assign tag_pv[i]   = tag_ff[i-1];
         end

         always_comb begin
            shift_val = {rem_pv[i], num_pv[i][QUO_W-1]};
            take      = shift_val >= {1'b0, den_pv[i]};
            rem_in    = take ? LEN_W'(shift_val - {1'b0, den_pv[i]}) : shift_val[LEN_W-1:0];
            num_in    = {num_pv[i][QUO_W-2:0], 1'b0};
            quo_in    = {quo_pv[i][QUO_W-2:0], take};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (advance) begin
               valid_ff[i] <= valid_pv[i];
            end
            if (advance) begin
               rem_ff[i] <= rem_in;
               num_ff[i] <= num_in;
               quo_ff[i] <= quo_in;
               den_ff[i] <= den_pv[i];
               tag_ff[i] <= tag_pv[i];
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_tag   = tag_ff[QUO_W-1];

endmodule

FILE: hdl/psd_sqrt.sv
// ----------------------------------------------------------------------------
// psd_sqrt
// pipelined integer square root, one root bit per stage, floor result
// ----------------------------------------------------------------------------
module psd_sqrt
   import psd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [QUO_W-1:0]    in_rad,
   input  tag_type             in_tag,
   output logic                out_valid,
   output logic [DIST_W-1:0]   out_root,
   output tag_type             out_tag
);

   logic                  valid_ff [DIST_W];
   logic [ROOT_REM_W-1:0] rem_ff   [DIST_W];
   logic [QUO_W-1:0]      rad_ff   [DIST_W];
   logic [DIST_W-1:0]     root_ff  [DIST_W];
   tag_type               tag_ff   [DIST_W];

   logic                  valid_pv [DIST_W];
   logic [ROOT_REM_W-1:0] rem_pv   [DIST_W];
   logic [QUO_W-1:0]      rad_pv   [DIST_W];
   logic [DIST_W-1:0]     root_pv  [DIST_W];
   tag_type               tag_pv   [DIST_W];

   genvar i;
   generate
      for (i = 0; i < DIST_W; i++) begin : g_stage
         logic [ROOT_REM_W-1:0] shift_val;
         logic [ROOT_REM_W-1:0] trial;
         logic                  take;
         logic [ROOT_REM_W-1:0] rem_in;
         logic [QUO_W-1:0]      rad_in;
         logic [DIST_W-1:0]     root_in;

         if (i == 0) begin : g_first
            assign valid_pv[i] = in_valid;
            assign rem_pv[i]   = '0;
            assign rad_pv[i]   = in_rad;
            assign root_pv[i]  = '0;
            assign tag_pv[i]   = in_tag;
         end else begin : g_next
            assign valid_pv[i] = valid_ff[i-1];
            assign rem_pv[i]   = rem_ff[i-1];
            assign rad_pv[i]   = rad_ff[i-1];
            assign root_pv[i]  = root_ff[i-1];
            assign tag_pv[i]   = tag_ff[i-1];
         end

         always_comb begin
            shift_val = {rem_pv[i][ROOT_REM_W-3:0], rad_pv[i][QUO_W-1:QUO_W-2]};
            trial     = ROOT_REM_W'({root_pv[i], 2'b01});
            take      = shift_val >= trial;
            rem_in    = take ? (shift_val - trial) : shift_val;
            rad_in    = {rad_pv[i][QUO_W-3:0], 2'b00};
            root_in   = {root_pv[i][DIST_W-2:0], take};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (advance) begin
               valid_ff[i] <= valid_pv[i];
            end
            if (advance) begin
               rem_ff[i]  <= rem_in;
               rad_ff[i]  <= rad_in;
               root_ff[i] <= root_in;
               tag_ff[i]  <= tag_pv[i];
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[DIST_W-1];
   assign out_root  = root_ff[DIST_W-1];
   assign out_tag   = tag_ff[DIST_W-1];

endmodule

FILE: hdl/point_segment_distance.sv
// ----------------------------------------------------------------------------
// point_segment_distance
// shortest distance from a point to a 2-d segment, fixed point result
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one item: query point and segment start and end, signed
//   pixels. rsp_* returns one item per query: truncated distance with 8
//   fraction bits, the region code and the degenerate flag.
//   both channels move an item on a clock edge with valid high, stall low.
//   the pipe has 6 front stages (differences, products, sums,
//   region choice, cross-product square in partial products, merge),
//   50 divider stages of one quotient bit each and 25 square-root stages
//   of one root bit each. one item is taken every cycle while req_stall
//   is low. the last root stage is the output register. while it holds
//   an item and rsp_stall is high the whole pipe freezes and req_stall
//   is raised; nothing is dropped or repeated.
//   reset clears all valid bits; the pipe is then empty and ready.
// ----------------------------------------------------------------------------
module point_segment_distance
   import psd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [DIST_W-1:0]            rsp_distance,
   output logic [1:0]                   rsp_region,
   output logic                         rsp_degenerate
);

   logic advance;

   // stage 1: differences
   logic                     v1_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, ax_ff, ay_ff, bx_ff, by_ff;

   // stage 2: products
   logic                     v2_ff;
   logic signed [PROD_W-1:0] dxdx_ff, dydy_ff, bxdx_ff, bydy_ff, axdx_ff, aydy_ff;
   logic signed [PROD_W-1:0] dxay_ff, dyax_ff, axax_ff, ayay_ff, bxbx_ff, byby_ff;
   logic                     degen2_ff;

   // stage 3: sums
   logic                    v3_ff;
   logic [LEN_W-1:0]        len2_ff, sqa_ff, sqb_ff;
   logic signed [SUM_W-1:0] dotb_ff, dota_ff, cross_ff;
   logic                    degen3_ff;

   // stage 4: region choice
   logic             v4_ff;
   tag_type          tag4_in, tag4_ff;
   logic [LEN_W-1:0] mag_in, mag4_ff, sq_in, sq4_ff, den_in, den4_ff;
   logic             perp_in, perp4_ff;
   logic [SUM_W-1:0] cross_abs;

   // stage 5: partial products of the cross-product square
   logic                v5_ff;
   tag_type             tag5_ff;
   logic [2*HALF_W-1:0] hh_ff, hl_ff, ll_ff;
   logic [LEN_W-1:0]    sq5_ff, den5_ff;
   logic                perp5_ff;

   // stage 6: numerator merge
   logic             v6_ff;
   tag_type          tag6_ff;
   logic [MAG_W-1:0] num_in, num6_ff;
   logic [LEN_W-1:0] den6_ff;

   logic             dv_valid;
   logic [QUO_W-1:0] dv_quo;
   tag_type          dv_tag;
   tag_type          sq_tag;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_comb begin
      cross_abs = cross_ff[SUM_W-1] ? SUM_W'(-cross_ff) : SUM_W'(cross_ff);
      mag_in    = cross_abs[LEN_W-1:0];
      den_in    = LEN_W'(1);
      perp_in   = 1'b0;
      sq_in     = sqa_ff;
      tag4_in.degenerate = degen3_ff;
      tag4_in.region     = REGION_START;
      if (degen3_ff) begin
         tag4_in.region = REGION_START;
      end else if (!dotb_ff[SUM_W-1] && dotb_ff != '0) begin
         tag4_in.region = REGION_END;
         sq_in          = sqb_ff;
      end else if (dota_ff[SUM_W-1]) begin
         tag4_in.region = REGION_START;
      end else begin
         tag4_in.region = REGION_PERP;
         perp_in        = 1'b1;
         den_in         = len2_ff;
      end
   end

   always_comb begin
      if (perp5_ff) begin
         num_in = (MAG_W'(hh_ff) << (2 * HALF_W))
                + (MAG_W'(hl_ff) << (HALF_W + 1))
                + MAG_W'(ll_ff);
      end else begin
         num_in = MAG_W'(sq5_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff <= DIFF_W'(req_end_x) - DIFF_W'(req_start_x);
         dy_ff <= DIFF_W'(req_end_y) - DIFF_W'(req_start_y);
         ax_ff <= DIFF_W'(req_point_x) - DIFF_W'(req_start_x);
         ay_ff <= DIFF_W'(req_point_y) - DIFF_W'(req_start_y);
         bx_ff <= DIFF_W'(req_point_x) - DIFF_W'(req_end_x);
         by_ff <= DIFF_W'(req_point_y) - DIFF_W'(req_end_y);

         dxdx_ff   <= dx_ff * dx_ff;
         dydy_ff   <= dy_ff * dy_ff;
         bxdx_ff   <= bx_ff * dx_ff;
         bydy_ff   <= by_ff * dy_ff;
         axdx_ff   <= ax_ff * dx_ff;
         aydy_ff   <= ay_ff * dy_ff;
         dxay_ff   <= dx_ff * ay_ff;
         dyax_ff   <= dy_ff * ax_ff;
         axax_ff   <= ax_ff * ax_ff;
         ayay_ff   <= ay_ff * ay_ff;
         bxbx_ff   <= bx_ff * bx_ff;
         byby_ff   <= by_ff * by_ff;
         degen2_ff <= (dx_ff == '0) && (dy_ff == '0);

         len2_ff   <= LEN_W'(dxdx_ff + dydy_ff);
         sqa_ff    <= LEN_W'(axax_ff + ayay_ff);
         sqb_ff    <= LEN_W'(bxbx_ff + byby_ff);
         dotb_ff   <= SUM_W'(bxdx_ff) + SUM_W'(bydy_ff);
         dota_ff   <= SUM_W'(axdx_ff) + SUM_W'(aydy_ff);
         cross_ff  <= SUM_W'(dxay_ff) - SUM_W'(dyax_ff);
         degen3_ff <= degen2_ff;

         tag4_ff  <= tag4_in;
         mag4_ff  <= mag_in;
         sq4_ff   <= sq_in;
         den4_ff  <= den_in;
         perp4_ff <= perp_in;

         tag5_ff  <= tag4_ff;
         hh_ff    <= mag4_ff[LEN_W-1:HALF_W] * mag4_ff[LEN_W-1:HALF_W];
         hl_ff    <= mag4_ff[LEN_W-1:HALF_W] * mag4_ff[HALF_W-1:0];
         ll_ff    <= mag4_ff[HALF_W-1:0] * mag4_ff[HALF_W-1:0];
         sq5_ff   <= sq4_ff;
         den5_ff  <= den4_ff;
         perp5_ff <= perp4_ff;

         tag6_ff <= tag5_ff;
         num6_ff <= num_in;
         den6_ff <= den5_ff;
      end
   end

   psd_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v6_ff),
      .in_num    (num6_ff),
      .in_den    (den6_ff),
      .in_tag    (tag6_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_tag   (dv_tag)
   );

   psd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dv_valid),
      .in_rad    (dv_quo),
      .in_tag    (dv_tag),
      .out_valid (rsp_valid),
      .out_root  (rsp_distance),
      .out_tag   (sq_tag)
   );

   assign rsp_region     = sq_tag.region;
   assign rsp_degenerate = sq_tag.degenerate;

   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_region == REGION_PERP || rsp_region == REGION_END
                     || rsp_region == REGION_START))
      else $error("bad region code on output");

   a_degen_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_region == REGION_START)
      else $error("degenerate item not in start region");

   a_freeze_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("pipe frozen without a held output item");

   a_frozen_front: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(v6_ff) && $stable(num6_ff))
      else $error("front stage moved while frozen");

endmodule
